>>> hdl/key_range_filter_sort_defines.svh
// Assertion macros shared by the key range filter sort RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef KEY_RANGE_FILTER_SORT_DEFINES_SVH
`define KEY_RANGE_FILTER_SORT_DEFINES_SVH

// Check that is held off while reset is asserted.
`define KRFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset.
`define KRFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/krfs_pkg.sv
// Types and constants of the key range filter sort block.
// Used by the configuration registers, the sort cells and the top level.
package krfs_pkg;

  localparam int KEY_W  = 32;
  localparam int PAY_W  = 64;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic {
    REG_LOW_BOUND  = 1'b0,
    REG_HIGH_BOUND = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_END    = 1'b1
  } kind_t;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic             last;
    logic             empty_res;
    logic             overflow;
  } out_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             shift;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

>>> hdl/krfs_cfg.sv
// Window bound registers behind the APB-style configuration port.
// Depends on krfs_pkg.
module krfs_cfg
  import krfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [KEY_W-1:0]  low_bound,
  output logic [KEY_W-1:0]  high_bound
);

  logic [KEY_W-1:0] low_r, low_nxt;
  logic [KEY_W-1:0] high_r, high_nxt;
  cfg_reg_t         sel;

  assign sel    = cfg_reg_t'(paddr[2]);
  assign pready = 1'b1;

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (psel && penable && pwrite) begin
      case (sel)
        REG_LOW_BOUND:  low_nxt  = pwdata[KEY_W-1:0];
        REG_HIGH_BOUND: high_nxt = pwdata[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_LOW_BOUND:  prdata = CFG_DW'(low_r);
      REG_HIGH_BOUND: prdata = CFG_DW'(high_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '1;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  assign low_bound  = low_r;
  assign high_bound = high_r;

endmodule

>>> hdl/krfs_cell.sv
// One cell of the insertion sort row: holds one record and its valid bit.
// Depends on krfs_pkg for the broadcast control struct.
module krfs_cell
  import krfs_pkg::*;
#(
  parameter int PW = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [PW-1:0]    ins_pay,
  input  logic             prev_v,
  input  logic [KEY_W-1:0] prev_key,
  input  logic [PW-1:0]    prev_pay,
  input  logic             prev_gt,
  input  logic             next_v,
  input  logic [KEY_W-1:0] next_key,
  input  logic [PW-1:0]    next_pay,
  output logic             v,
  output logic [KEY_W-1:0] key,
  output logic [PW-1:0]    pay,
  output logic             gt
);

  logic             v_r, v_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PW-1:0]    pay_r, pay_nxt;

  // An empty cell counts as holding a key above every real key.
  assign gt = !v_r || (key_r > ctl.key);

  always_comb begin
    v_nxt   = v_r;
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (ctl.shift) begin
      v_nxt   = next_v;
      key_nxt = next_key;
      pay_nxt = next_pay;
    end else if (ctl.ins && gt) begin
      // If the left neighbor is also larger, the row moves right by one here.
      if (prev_gt) begin
        v_nxt   = prev_v;
        key_nxt = prev_key;
        pay_nxt = prev_pay;
      end else begin
        v_nxt   = 1'b1;
        key_nxt = ctl.key;
        pay_nxt = ins_pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign v   = v_r;
  assign key = key_r;
  assign pay = pay_r;

endmodule

>>> hdl/key_range_filter_sort.sv
// Range filter and stable ascending sort over a row of CAPACITY insertion cells.
// Records: one transfer per cycle while in_stall is low; a kept record moves from the
// input stage register into the row. End item: results leave the output register one per
// cycle while out_stall is low, as the row shifts toward it; input beyond one staged item waits.
// Reset (synchronous, rst_n low) empties the row and restores the window bounds.
`include "key_range_filter_sort_defines.svh"

module key_range_filter_sort
  import krfs_pkg::*;
#(
  parameter int CAPACITY      = 64,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int PW = PAYLOAD_WIDTH;

  logic [KEY_W-1:0] low_bound, high_bound;

  krfs_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .low_bound  (low_bound),
    .high_bound (high_bound)
  );

  // Input stage.
  logic             stg_v_r, stg_v_nxt;
  logic             stg_kind_r;
  logic [KEY_W-1:0] stg_key_r;
  logic [PW-1:0]    stg_pay_r;
  logic             stg_inr_r;
  logic             in_acc, proc;

  logic drain_r, drain_nxt;
  logic dropped_r, dropped_nxt;
  logic out_v_r, out_v_nxt;
  out_t out_r, out_nxt;
  logic ld;

  cell_ctl_t ctl;

  logic             cv [CAPACITY];
  logic [KEY_W-1:0] ck [CAPACITY];
  logic [PW-1:0]    cp [CAPACITY];
  logic             cg [CAPACITY];
  logic [CAPACITY-1:0] vvec;
  logic [CAPACITY-2:0] order_bad;
  logic [CAPACITY:0]   vplus1;
  logic                full;

  assign in_stall = stg_v_r && drain_r;
  assign in_acc   = in_valid && !in_stall;
  assign proc     = stg_v_r && !drain_r;
  assign full     = cv[CAPACITY-1];

  assign stg_v_nxt = in_acc ? 1'b1 : (proc ? 1'b0 : stg_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_kind_r <= in_data.kind;
      stg_key_r  <= in_data.key;
      stg_pay_r  <= in_data.payload[PW-1:0];
      stg_inr_r  <= (in_data.key >= low_bound) && (in_data.key <= high_bound);
    end
  end

  // While draining, the output register is free or being emptied this cycle.
  assign ld = drain_r && (!out_v_r || !out_stall);

  always_comb begin
    ctl.ins     = 1'b0;
    ctl.shift   = 1'b0;
    ctl.key     = stg_key_r;
    drain_nxt   = drain_r;
    dropped_nxt = dropped_r;
    out_v_nxt   = (out_v_r && !out_stall) ? 1'b0 : out_v_r;
    out_nxt     = out_r;
    if (proc) begin
      case (kind_t'(stg_kind_r))
        KIND_RECORD: begin
          if (stg_inr_r) begin
            if (full) begin
              dropped_nxt = 1'b1;
            end else begin
              ctl.ins = 1'b1;
            end
          end
        end
        KIND_END: drain_nxt = 1'b1;
        default: ;
      endcase
    end
    if (ld) begin
      out_v_nxt            = 1'b1;
      out_nxt.overflow     = dropped_r;
      if (cv[0]) begin
        ctl.shift           = 1'b1;
        out_nxt.out_key     = ck[0];
        out_nxt.out_payload = PAY_W'(cp[0]);
        out_nxt.last        = !cv[1];
        out_nxt.empty_res   = 1'b0;
        if (!cv[1]) begin
          drain_nxt   = 1'b0;
          dropped_nxt = 1'b0;
        end
      end else begin
        // Nothing was kept in this set.
        out_nxt.out_key     = '0;
        out_nxt.out_payload = '0;
        out_nxt.last        = 1'b1;
        out_nxt.empty_res   = 1'b1;
        drain_nxt           = 1'b0;
        dropped_nxt         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r   <= 1'b0;
      dropped_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      drain_r   <= drain_nxt;
      dropped_r <= dropped_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             p_v, p_gt, n_v;
    logic [KEY_W-1:0] p_key, n_key;
    logic [PW-1:0]    p_pay, n_pay;

    if (i == 0) begin : g_first
      assign p_v   = 1'b0;
      assign p_gt  = 1'b0;
      assign p_key = '0;
      assign p_pay = '0;
    end else begin : g_mid
      assign p_v   = cv[i-1];
      assign p_gt  = cg[i-1];
      assign p_key = ck[i-1];
      assign p_pay = cp[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign n_v   = 1'b0;
      assign n_key = '0;
      assign n_pay = '0;
    end else begin : g_inner
      assign n_v   = cv[i+1];
      assign n_key = ck[i+1];
      assign n_pay = cp[i+1];
    end

    krfs_cell #(.PW(PW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .ins_pay  (stg_pay_r),
      .prev_v   (p_v),
      .prev_key (p_key),
      .prev_pay (p_pay),
      .prev_gt  (p_gt),
      .next_v   (n_v),
      .next_key (n_key),
      .next_pay (n_pay),
      .v        (cv[i]),
      .key      (ck[i]),
      .pay      (cp[i]),
      .gt       (cg[i])
    );

    assign vvec[i] = cv[i];
  end

  for (genvar i = 0; i < CAPACITY - 1; i++) begin : g_order
    assign order_bad[i] = cv[i+1] && (ck[i] > ck[i+1]);
  end

  assign vplus1 = {1'b0, vvec} + (CAPACITY+1)'(1);

  // Occupied cells always form one run starting at cell zero.
  `KRFS_ASSERT(a_row_packed, $onehot(vplus1), "sort row has a hole")
  // Neighboring records are never out of ascending order.
  `KRFS_ASSERT(a_row_sorted, order_bad == '0, "sort row out of order")
  // A drop is only recorded while the row is full.
  `KRFS_ASSERT(a_drop_full, (dropped_r && !drain_r) |-> full, "drop flag without full row")
  // An empty result is a lone, final, zero result.
  `KRFS_ASSERT(a_empty_res,
    (out_v_r && out_r.empty_res) |-> (out_r.last && out_r.out_key == '0),
    "malformed empty result")

endmodule
